// File: rtl/pre_pkg.sv
// Types and constants shared across the pulse rate estimator.
package pre_pkg;

	localparam int IR_W       = 18;
	localparam int TIME_W     = 32;
	localparam int BPM_W      = 16;
	localparam int LIMIT_W    = 8;
	localparam int WEIGHT_W   = 9;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_FINGER_THRESHOLD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABNORMAL_HIGH_BPM = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ABNORMAL_LOW_BPM  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT        = 4'd3;

	localparam logic [IR_W-1:0]     RST_FINGER_THRESHOLD  = 18'd50000;
	localparam logic [LIMIT_W-1:0]  RST_ABNORMAL_HIGH_BPM = 8'd120;
	localparam logic [LIMIT_W-1:0]  RST_ABNORMAL_LOW_BPM  = 8'd50;
	localparam logic [WEIGHT_W-1:0] RST_EMA_WEIGHT        = 9'd90;

	// serial divider: quotient always fits QUO_W bits for both uses
	localparam int DIV_W = 24;
	localparam int DVS_W = 12;
	localparam int QUO_W = 16;

	localparam int DELTA_W = 12;
	localparam logic [DIV_W-1:0]   BPM_NUM_Q8   = 24'd15360000;
	localparam logic [DELTA_W-1:0] MIN_INTERVAL = 12'd350;
	localparam logic [DELTA_W-1:0] MAX_INTERVAL = 12'd2500;

	localparam logic [BPM_W-1:0] WARM_LO  = 16'd10240;
	localparam logic [BPM_W-1:0] WARM_HI  = 16'd51200;
	localparam logic [BPM_W-1:0] TRUST_LO = 16'd14080;
	localparam logic [BPM_W-1:0] TRUST_HI = 16'd30720;
	localparam logic [BPM_W-1:0] FLOOR_Q8 = 16'd5120;
	localparam logic [BPM_W-1:0] CEIL_Q8  = 16'd65280;

	localparam int WARM_COUNT    = 5;
	localparam int OUTLIER_COUNT = 3;

	localparam int PROD_W = WEIGHT_W + BPM_W;
	localparam logic [WEIGHT_W-1:0] OUTLIER_SCALE = 9'd100;
	localparam logic [WEIGHT_W-1:0] OUTLIER_LO    = 9'd55;
	localparam logic [WEIGHT_W-1:0] OUTLIER_HI    = 9'd145;
	localparam logic [WEIGHT_W-1:0] EMA_ONE       = 9'd256;
	localparam logic [PROD_W:0]     EMA_ROUND     = 26'd128;

	typedef struct packed {
		logic [IR_W-1:0]     finger_threshold;
		logic [LIMIT_W-1:0]  abnormal_high_bpm;
		logic [LIMIT_W-1:0]  abnormal_low_bpm;
		logic [WEIGHT_W-1:0] ema_weight;
	} pre_cfg_t;

	typedef struct packed {
		logic [IR_W-1:0]   ir_level;
		logic              beat_seen;
		logic [TIME_W-1:0] time_ms;
		logic              last_of_pass;
	} pre_sample_t;

	typedef struct packed {
		logic [BPM_W-1:0] bpm_average;
		logic             finger_present;
		logic             rate_abnormal;
	} pre_result_t;

endpackage

// File: rtl/pre_div.sv
// Restoring serial divider, one quotient bit per cycle.
module pre_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pre_pkg::DIV_W-1:0]   dividend,
	input  logic [pre_pkg::DVS_W-1:0]   divisor,
	output logic                        done,
	output logic [pre_pkg::QUO_W-1:0]   quotient
);
	import pre_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, num_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(DVS_W - (DIV_W - QUO_W)){1'b0}}, dividend[DIV_W-1:QUO_W]};
			num_q <= dividend[QUO_W-1:0];
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			num_q <= {num_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/pre_core.sv
// Sequencer, rate window and smoothing datapath around the shared divider and multiplier.
module pre_core #(
	parameter int WINDOW_SIZE = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pre_pkg::pre_cfg_t     cfg,
	input  logic                  sample_valid,
	input  pre_pkg::pre_sample_t  sample,
	output logic                  busy,
	output logic                  res_ready,
	input  logic                  res_free,
	output pre_pkg::pre_result_t  res
);
	import pre_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
	localparam int SLOT_W = $clog2(WINDOW_SIZE);
	localparam int SUM_W  = BPM_W + CNT_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_BSTART = 4'd1;
	localparam logic [3:0] S_DIVB   = 4'd2;
	localparam logic [3:0] S_CHK    = 4'd3;
	localparam logic [3:0] S_MA     = 4'd4;
	localparam logic [3:0] S_MB     = 4'd5;
	localparam logic [3:0] S_MC     = 4'd6;
	localparam logic [3:0] S_UPD    = 4'd7;
	localparam logic [3:0] S_MSTART = 4'd8;
	localparam logic [3:0] S_DIVM   = 4'd9;
	localparam logic [3:0] S_E1     = 4'd10;
	localparam logic [3:0] S_E2     = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [3:0]         state_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TIME_W-1:0]  last_q;
	logic               armed_q;
	logic [BPM_W-1:0]   smooth_q;
	logic [BPM_W-1:0]   mean_q;
	logic               finger_q;
	logic               strong_pass_q;
	logic [DELTA_W-1:0] delta_q;
	logic [BPM_W-1:0]   bpm_q;
	logic [PROD_W-1:0]  p_q;
	logic [BPM_W-1:0]   ring_q [WINDOW_SIZE];

	logic               fire;
	logic               above_thr;
	logic               armed_eff;
	logic [TIME_W-1:0]  last_eff;
	logic [TIME_W-1:0]  delta;
	logic               delta_ok;
	logic [BPM_W-1:0]   band_lo;
	logic [BPM_W-1:0]   band_hi;
	logic [WEIGHT_W-1:0] w;
	logic [WEIGHT_W-1:0] mul_a;
	logic [BPM_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W:0]    ema_sum;
	logic [BPM_W-1:0]   old_entry;
	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DVS_W-1:0]   div_divisor;
	logic               div_done;
	logic [QUO_W-1:0]   div_quo;

	assign fire      = sample_valid && (state_q == S_IDLE);
	assign busy      = state_q != S_IDLE;
	assign res_ready = state_q == S_FIN;

	always_comb begin
		above_thr = sample.ir_level > cfg.finger_threshold;
		armed_eff = finger_q && armed_q;
		last_eff  = finger_q ? last_q : '0;
		delta     = sample.time_ms - last_eff;
		delta_ok  = (delta >= TIME_W'(MIN_INTERVAL)) && (delta <= TIME_W'(MAX_INTERVAL));
		band_lo   = (count_q < CNT_W'(WARM_COUNT)) ? WARM_LO : TRUST_LO;
		band_hi   = (count_q < CNT_W'(WARM_COUNT)) ? WARM_HI : TRUST_HI;
		w         = (cfg.ema_weight > EMA_ONE) ? EMA_ONE : cfg.ema_weight;
		old_entry = (count_q == CNT_W'(WINDOW_SIZE)) ? ring_q[slot_q] : '0;
	end

	// shared multiplier
	always_comb begin
		unique case (state_q)
			S_MA: begin
				mul_a = OUTLIER_SCALE;
				mul_b = bpm_q;
			end
			S_MB: begin
				mul_a = OUTLIER_LO;
				mul_b = mean_q;
			end
			S_MC: begin
				mul_a = OUTLIER_HI;
				mul_b = mean_q;
			end
			S_E1: begin
				mul_a = w;
				mul_b = mean_q;
			end
			S_E2: begin
				mul_a = EMA_ONE - w;
				mul_b = smooth_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		ema_sum = {1'b0, p_q} + {1'b0, prod} + EMA_ROUND;
	end

	always_comb begin
		div_start = (state_q == S_BSTART) || (state_q == S_MSTART);
		if (state_q == S_BSTART) begin
			div_dividend = BPM_NUM_Q8 + DIV_W'(delta_q >> 1);
			div_divisor  = DVS_W'(delta_q);
		end else begin
			div_dividend = DIV_W'(sum_q) + DIV_W'(count_q >> 1);
			div_divisor  = DVS_W'(count_q);
		end
	end

	pre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			slot_q        <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			last_q        <= '0;
			armed_q       <= 1'b0;
			smooth_q      <= '0;
			mean_q        <= '0;
			finger_q      <= 1'b0;
			strong_pass_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						state_q <= S_FIN;
						if (above_thr) begin
							strong_pass_q <= 1'b1;
							if (!finger_q) begin
								slot_q   <= '0;
								count_q  <= '0;
								sum_q    <= '0;
								last_q   <= '0;
								armed_q  <= 1'b0;
								smooth_q <= '0;
								mean_q   <= '0;
								finger_q <= 1'b1;
							end
							if (sample.beat_seen) begin
								last_q  <= sample.time_ms;
								armed_q <= 1'b1;
								if (armed_eff && delta_ok) begin
									state_q <= S_BSTART;
								end
							end
						end
						if (sample.last_of_pass) begin
							if (!(strong_pass_q || above_thr)) begin
								slot_q   <= '0;
								count_q  <= '0;
								sum_q    <= '0;
								last_q   <= '0;
								armed_q  <= 1'b0;
								smooth_q <= '0;
								mean_q   <= '0;
								finger_q <= 1'b0;
							end
							strong_pass_q <= 1'b0;
						end
					end
				end
				S_BSTART: state_q <= S_DIVB;
				S_DIVB: begin
					if (div_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					priority if (bpm_q < FLOOR_Q8 || bpm_q > CEIL_Q8) begin
						state_q <= S_FIN;
					end else if (bpm_q >= band_lo && bpm_q <= band_hi) begin
						state_q <= S_UPD;
					end else if (count_q >= CNT_W'(OUTLIER_COUNT) && mean_q != '0) begin
						state_q <= S_MA;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= (p_q < prod) ? S_FIN : S_MC;
				S_MC: state_q <= (p_q > prod) ? S_FIN : S_UPD;
				S_UPD: begin
					sum_q   <= sum_q - SUM_W'(old_entry) + SUM_W'(bpm_q);
					slot_q  <= (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
					if (count_q != CNT_W'(WINDOW_SIZE)) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_MSTART;
				end
				S_MSTART: state_q <= S_DIVM;
				S_DIVM: begin
					if (div_done) begin
						mean_q <= div_quo;
						priority if (div_quo == '0) begin
							state_q <= S_FIN;
						end else if (smooth_q == '0) begin
							smooth_q <= div_quo;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_E1;
						end
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: begin
					smooth_q <= ema_sum[BPM_W+7:8];
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			delta_q <= delta[DELTA_W-1:0];
		end
		if (state_q == S_DIVB && div_done) begin
			bpm_q <= div_quo;
		end
		if (state_q == S_MA || state_q == S_E1) begin
			p_q <= prod;
		end
		if (state_q == S_UPD) begin
			ring_q[slot_q] <= bpm_q;
		end
	end

	always_comb begin
		res.bpm_average    = smooth_q;
		res.finger_present = finger_q;
		res.rate_abnormal  = finger_q && (smooth_q != '0) &&
			((smooth_q > {cfg.abnormal_high_bpm, 8'h00}) ||
			 (smooth_q < {cfg.abnormal_low_bpm, 8'h00}));
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_SIZE))
		else $error("window count beyond depth");

	a_no_finger_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!finger_q |-> (count_q == '0 && smooth_q == '0 && !armed_q))
		else $error("estimator not cleared without finger");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> (sum_q == '0 && mean_q == '0))
		else $error("empty window with nonzero sum or mean");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> busy)
		else $error("item accepted but sequencer stayed idle");

endmodule

// File: rtl/pulse_rate_estimator.sv
// Pulse rate estimator top level: configuration registers, core and result register.
//
// One IR sample per item. An item that carries no timed beat goes from the
// accept cycle straight to the result state, which loads the result register
// once that register is free. A beat whose interval falls in the 350 to 2500
// ms range makes one 16-step pass through the shared serial divider (beat BPM)
// when the window turns it away and a second one (window mean) when it is
// taken, plus up to five steps of the shared 9x16 multiplier for the outlier
// test and the EMA. sample_stall is high while an item is in work; a
// finished result waits in the output register while the next item is taken.
// The rate window holds WINDOW_SIZE entries. Configuration writes are taken
// at any time (cfg_ready is always high) and belong only in idle periods.
module pulse_rate_estimator #(
	parameter int WINDOW_SIZE = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic [pre_pkg::IR_W-1:0]        ir_level,
	input  logic                            beat_seen,
	input  logic [pre_pkg::TIME_W-1:0]      time_ms,
	input  logic                            last_of_pass,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [pre_pkg::BPM_W-1:0]       bpm_average,
	output logic                            finger_present,
	output logic                            rate_abnormal,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pre_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pre_pkg::*;

	pre_cfg_t    cfg_q;
	pre_sample_t sample;
	pre_result_t res;
	pre_result_t res_q;
	logic        result_valid_q;
	logic        busy;
	logic        res_ready;
	logic        res_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.finger_threshold  <= RST_FINGER_THRESHOLD;
			cfg_q.abnormal_high_bpm <= RST_ABNORMAL_HIGH_BPM;
			cfg_q.abnormal_low_bpm  <= RST_ABNORMAL_LOW_BPM;
			cfg_q.ema_weight        <= RST_EMA_WEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FINGER_THRESHOLD:  cfg_q.finger_threshold  <= cfg_data[IR_W-1:0];
				REG_ABNORMAL_HIGH_BPM: cfg_q.abnormal_high_bpm <= cfg_data[LIMIT_W-1:0];
				REG_ABNORMAL_LOW_BPM:  cfg_q.abnormal_low_bpm  <= cfg_data[LIMIT_W-1:0];
				REG_EMA_WEIGHT:        cfg_q.ema_weight        <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sample.ir_level     = ir_level;
		sample.beat_seen    = beat_seen;
		sample.time_ms      = time_ms;
		sample.last_of_pass = last_of_pass;
	end

	assign res_free = !result_valid_q || !result_stall;

	pre_core #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample       (sample),
		.busy         (busy),
		.res_ready    (res_ready),
		.res_free     (res_free),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready && res_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_free) begin
			res_q <= res;
		end
	end

	assign sample_stall   = busy;
	assign result_valid   = result_valid_q;
	assign bpm_average    = res_q.bpm_average;
	assign finger_present = res_q.finger_present;
	assign rate_abnormal  = res_q.rate_abnormal;

endmodule

// File: sim/pulse_rate_estimator_tb.sv
// Self-checking testbench for pulse_rate_estimator: directed, register and random rhythm tests.
module pulse_rate_estimator_tb;
	import pre_pkg::*;

	localparam int          WIN            = 10;
	localparam int unsigned BEAT_NUM       = 15360000;
	localparam int unsigned SHORTEST_MS    = 350;
	localparam int unsigned LONGEST_MS     = 2500;
	localparam int unsigned WARM_LO_Q8     = 10240;
	localparam int unsigned WARM_HI_Q8     = 51200;
	localparam int unsigned TRUST_LO_Q8    = 14080;
	localparam int unsigned TRUST_HI_Q8    = 30720;
	localparam int unsigned BPM_FLOOR      = 5120;
	localparam int unsigned BPM_CEIL       = 65280;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	logic [IR_W-1:0]       ir_level;
	logic                  beat_seen;
	logic [TIME_W-1:0]     time_ms;
	logic                  last_of_pass;
	logic                  result_valid;
	logic                  result_stall;
	logic [BPM_W-1:0]      bpm_average;
	logic                  finger_present;
	logic                  rate_abnormal;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pulse_rate_estimator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.ir_level       (ir_level),
		.beat_seen      (beat_seen),
		.time_ms        (time_ms),
		.last_of_pass   (last_of_pass),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.bpm_average    (bpm_average),
		.finger_present (finger_present),
		.rate_abnormal  (rate_abnormal),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// estimator copy
	pre_cfg_t    cfg_now;
	logic [15:0] rate_hist [WIN];
	int unsigned hist_slot;
	int unsigned hist_count;
	int unsigned hist_sum;
	logic [31:0] prev_beat_ms;
	bit          beat_armed;
	logic [15:0] ema_bpm;
	bit          finger_seen;
	bit          strong_seen;

	pre_result_t expected_results [$];
	int          mismatch_count;
	int          quiet_cycles;
	bit          hold_req;
	bit          no_idle;

	// rhythm generator
	logic [31:0] t_now;
	int unsigned since_beat;
	int unsigned beat_target;
	int unsigned base_ms;
	int          pass_len;
	int          pass_pos;
	bit          weak_pass;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_estimate();
		foreach (rate_hist[i])
			rate_hist[i] = '0;
		hist_slot    = 0;
		hist_count   = 0;
		hist_sum     = 0;
		prev_beat_ms = '0;
		beat_armed   = 1'b0;
		ema_bpm      = '0;
	endfunction

	function automatic void model_reset();
		cfg_now.finger_threshold  = 18'd50000;
		cfg_now.abnormal_high_bpm = 8'd120;
		cfg_now.abnormal_low_bpm  = 8'd50;
		cfg_now.ema_weight        = 9'd90;
		clear_estimate();
		finger_seen = 1'b0;
		strong_seen = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FINGER_THRESHOLD:  cfg_now.finger_threshold  = data[IR_W-1:0];
			REG_ABNORMAL_HIGH_BPM: cfg_now.abnormal_high_bpm = data[LIMIT_W-1:0];
			REG_ABNORMAL_LOW_BPM:  cfg_now.abnormal_low_bpm  = data[LIMIT_W-1:0];
			REG_EMA_WEIGHT:        cfg_now.ema_weight        = data[WEIGHT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int unsigned hist_mean();
		if (hist_count == 0)
			return 0;
		return (hist_sum + hist_count / 2) / hist_count;
	endfunction

	function automatic void time_beat(input logic [31:0] now);
		logic [31:0] delta;
		int unsigned bpm, mean, lo, hi, w, next_ema;
		bit take;
		if (!beat_armed) begin
			prev_beat_ms = now;
			beat_armed   = 1'b1;
			return;
		end
		delta        = now - prev_beat_ms;
		prev_beat_ms = now;
		if (delta < SHORTEST_MS || delta > LONGEST_MS)
			return;
		bpm = (BEAT_NUM + delta / 2) / delta;
		if (bpm < BPM_FLOOR || bpm > BPM_CEIL)
			return;
		mean = hist_mean();
		lo   = (hist_count < 5) ? WARM_LO_Q8 : TRUST_LO_Q8;
		hi   = (hist_count < 5) ? WARM_HI_Q8 : TRUST_HI_Q8;
		if (bpm >= lo && bpm <= hi)
			take = 1'b1;
		else if (hist_count >= 3 && mean > 0)
			take = !(bpm * 100 < mean * 55 || bpm * 100 > mean * 145);
		else
			take = 1'b0;
		if (!take)
			return;
		if (hist_slot >= WIN)
			hist_slot = 0;
		hist_sum             = hist_sum - rate_hist[hist_slot] + bpm;
		rate_hist[hist_slot] = bpm[15:0];
		hist_slot            = (hist_slot + 1) % WIN;
		if (hist_count < WIN)
			hist_count++;
		mean = hist_mean();
		if (mean > 0) begin
			if (ema_bpm != 0) begin
				w        = (cfg_now.ema_weight > 256) ? 256 : cfg_now.ema_weight;
				next_ema = (w * mean + (256 - w) * ema_bpm + 128) >> 8;
			end else begin
				next_ema = mean;
			end
			ema_bpm = next_ema[15:0];
		end
	endfunction

	function automatic pre_result_t predict_result(input pre_sample_t s);
		pre_result_t r;
		if (s.ir_level > cfg_now.finger_threshold) begin
			strong_seen = 1'b1;
			if (!finger_seen) begin
				clear_estimate();
				finger_seen = 1'b1;
			end
			if (s.beat_seen)
				time_beat(s.time_ms);
		end
		if (s.last_of_pass) begin
			if (!strong_seen) begin
				if (finger_seen)
					clear_estimate();
				finger_seen = 1'b0;
			end
			strong_seen = 1'b0;
		end
		r.bpm_average    = ema_bpm;
		r.finger_present = finger_seen;
		r.rate_abnormal  = finger_seen && ema_bpm != 0 &&
				(ema_bpm > {cfg_now.abnormal_high_bpm, 8'h00} ||
				ema_bpm < {cfg_now.abnormal_low_bpm, 8'h00});
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic send_sample(input logic [IR_W-1:0] ir, input logic beat,
			input logic [TIME_W-1:0] ts, input logic last);
		pre_sample_t s;
		int g;
		s.ir_level     = ir;
		s.beat_seen    = beat;
		s.time_ms      = ts;
		s.last_of_pass = last;
		@(negedge clk);
		sample_valid = 1'b1;
		ir_level     = ir;
		beat_seen    = beat;
		time_ms      = ts;
		last_of_pass = last;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		expected_results.push_back(predict_result(s));
		g = no_idle ? 0 : gap_len();
		if (g > 0) begin
			@(negedge clk);
			sample_valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		sample_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// upper data bits carry junk to check field masking
	task automatic set_config(input logic [IR_W-1:0] thr, input logic [LIMIT_W-1:0] hi,
			input logic [LIMIT_W-1:0] lo, input logic [WEIGHT_W-1:0] w);
		wait_drained();
		write_reg(REG_FINGER_THRESHOLD, thr);
		write_reg(REG_ABNORMAL_HIGH_BPM, {10'($urandom), hi});
		write_reg(REG_ABNORMAL_LOW_BPM, {10'($urandom), lo});
		write_reg(REG_EMA_WEIGHT, {9'($urandom), w});
		write_reg(4'($urandom_range(4, 15)), 18'($urandom));
	endtask

	function automatic logic [IR_W-1:0] weak_level();
		return 18'($urandom_range(0, cfg_now.finger_threshold));
	endfunction

	function automatic logic [IR_W-1:0] strong_level();
		if (cfg_now.finger_threshold == 18'h3FFFF)
			return 18'h3FFFF;
		return 18'($urandom_range(cfg_now.finger_threshold + 1, 18'h3FFFF));
	endfunction

	function automatic int unsigned next_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			base_ms = $urandom_range(300, 1500);
		if (r >= 3 && r < 6)
			return $urandom_range(100, 349);
		if (r >= 6 && r < 9)
			return $urandom_range(2501, 4000);
		return base_ms * $urandom_range(88, 112) / 100;
	endfunction

	// passes of samples with a beat train; a few weak samples, weak passes and noise items
	task automatic send_rhythm(input int n, input int noise_pct);
		int i, dt, r;
		logic [IR_W-1:0] ir;
		logic beat, last;
		for (i = 0; i < n; i++) begin
			dt         = $urandom_range(8, 40);
			t_now      = t_now + dt;
			since_beat = since_beat + dt;
			beat       = 1'b0;
			if (since_beat >= beat_target) begin
				beat        = 1'b1;
				since_beat  = 0;
				beat_target = next_interval();
			end
			last = (pass_pos + 1 >= pass_len);
			r    = $urandom_range(0, 99);
			if (r < noise_pct) begin
				send_sample(18'($urandom), ($urandom_range(0, 3) == 0), $urandom,
						1'($urandom));
			end else begin
				ir = (weak_pass || r >= 97) ? weak_level() : strong_level();
				if (r == 96)
					beat = 1'b1;
				send_sample(ir, beat, t_now, last);
			end
			if (last) begin
				pass_pos  = 0;
				pass_len  = $urandom_range(1, 40);
				weak_pass = ($urandom_range(0, 99) < 4);
			end else begin
				pass_pos++;
			end
		end
	endtask

	task automatic test_directed();
		send_sample(18'd0, 1'b1, 32'd0, 1'b0);
		send_sample(18'd50000, 1'b1, 32'd100, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd1000, 1'b0);
		send_sample(18'd50001, 1'b1, 32'd1349, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd1699, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd4199, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd6700, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd7500, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd8300, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd9100, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd9900, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd10700, 1'b0);
		// fast beat outside the trust band and the outlier band, then a normal one, then one in the outlier band
		send_sample(18'h3FFFF, 1'b1, 32'd11100, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd11700, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'd12160, 1'b0);
		send_sample(18'h3FFFF, 1'b0, 32'd12200, 1'b1);
		send_sample(18'd10, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_sample(18'h3FFFF, 1'b1, 32'hFFFF_FE00, 1'b0);
		send_sample(18'h3FFFF, 1'b1, 32'h0000_0100, 1'b0);
		send_sample(18'd0, 1'b0, 32'h0000_0200, 1'b1);
	endtask

	task automatic test_register_extremes();
		set_config(18'd0, 8'd255, 8'd0, 9'd0);
		send_rhythm(120, 3);
		set_config(18'h3FFFF, 8'd0, 8'd255, 9'd256);
		send_rhythm(60, 3);
		set_config(18'd1000, 8'd80, 8'd60, 9'h1FF);
		send_rhythm(120, 3);
		set_config(18'd30000, 8'd0, 8'd0, 9'd257);
		send_rhythm(120, 3);
		set_config(18'h3FFFE, 8'd255, 8'd255, 9'd256);
		send_rhythm(80, 3);
		set_config(18'd50000, 8'd120, 8'd50, 9'd90);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		send_rhythm(200, 3);
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		no_idle  = 1'b1;
		hold_req = 1'b1;
		send_rhythm(40, 0);
		no_idle  = 1'b0;
	endtask

	task automatic test_random_rhythm();
		int ph;
		logic [IR_W-1:0] thr;
		logic [LIMIT_W-1:0] hi, lo;
		logic [WEIGHT_W-1:0] w;
		for (ph = 0; ph < 6; ph++) begin
			thr = ($urandom_range(0, 9) == 0) ? 18'($urandom) : 18'($urandom_range(20000, 80000));
			hi  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(90, 200));
			lo  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(30, 80));
			w   = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
			set_config(thr, hi, lo, w);
			if (ph == 3)
				t_now = 32'hFFFF_C000;
			send_rhythm(210, 3);
		end
	endtask

	// result side: random stalls, no stall while no_idle is set, or one long hold-off when asked
	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req     = 1'b0;
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall = 1'b0;
			end else if (no_idle) begin
				result_stall = 1'b0;
			end else begin
				n = gap_len();
				if (n == 0) begin
					result_stall = 1'b0;
				end else begin
					result_stall = 1'b1;
					repeat (n - 1) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		pre_result_t want;
		if (result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", bpm_average, 0);
			end else begin
				want = expected_results.pop_front();
				if (bpm_average !== want.bpm_average)
					report_mismatch("bpm_average", bpm_average, want.bpm_average);
				if (finger_present !== want.finger_present)
					report_mismatch("finger_present", finger_present, want.finger_present);
				if (rate_abnormal !== want.rate_abnormal)
					report_mismatch("rate_abnormal", rate_abnormal, want.rate_abnormal);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		ir_level       = '0;
		beat_seen      = 1'b0;
		time_ms        = '0;
		last_of_pass   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		hold_req       = 1'b0;
		no_idle        = 1'b0;
		t_now          = 32'd20000;
		since_beat     = 0;
		beat_target    = 800;
		base_ms        = 800;
		pass_len       = 20;
		pass_pos       = 0;
		weak_pass      = 1'b0;
		model_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_extremes();
		test_back_to_back();
		test_backpressure();
		test_random_rhythm();

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
rtl/pre_pkg.sv
rtl/pre_div.sv
rtl/pre_core.sv
rtl/pulse_rate_estimator.sv
sim/pulse_rate_estimator_tb.sv
